### src/ddw_pkg.sv
// Shared types and constants of the differential drive wheel PI speed controller.
// Used by the shared multiplier and the top level; depends on nothing.
package ddw_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int NOMINAL_STEP = 131;
    localparam int STOP_THRESH  = (1 << FRAC_BITS) / 100;

    localparam int TIME_W   = 48;
    localparam int SPEED_W  = 24;
    localparam int TORQUE_W = 19;
    localparam int INTEG_W  = 40;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int HALF_W  = 24;
    localparam int ACC_W   = 82;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIN_VEL    = 3'd0,
        CFG_ANG_VEL    = 3'd1,
        CFG_HALF_TRACK = 3'd2,
        CFG_INV_RADIUS = 3'd3,
        CFG_KP         = 3'd4,
        CFG_KI         = 3'd5,
        CFG_FRICTION   = 3'd6,
        CFG_TQ_LIMIT   = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TURN,
        ST_SUMS,
        ST_TGT_R,
        ST_TGT_L,
        ST_TGT_W,
        ST_ERR,
        ST_DLO,
        ST_DHI,
        ST_DACC,
        ST_INTEG,
        ST_ILO,
        ST_IHI,
        ST_IACC,
        ST_TORQ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage

### src/ddw_mul.sv
// Shared signed multiplier with registered product.
// Depends on ddw_pkg for operand widths and the request struct.
module ddw_mul import ddw_pkg::*; (
    input  logic                     i_clk,
    input  t_mul_req                 i_req,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [MUL_A_W-1:0] w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic signed [PROD_W-1:0]  r_prod;

    assign w_a = i_req.a;
    assign w_b = i_req.b;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= PROD_W'(w_a) * PROD_W'(w_b);
        end
    end

    assign o_prod = r_prod;

endmodule

### src/diff_drive_wheel_pi_speed_control.sv
// Differential drive wheel PI speed controller: targets, integrators, torque saturation.
// Depends on ddw_pkg and the shared multiplier ddw_mul.
//
//  channel | direction | handshake                       | word
//  input   | in        | s_axis_tvalid / s_axis_tready   | s_axis_tdata: time, speed R, speed L
//  output  | out       | m_axis_tvalid / m_axis_tready   | m_axis_tdata: torque R, torque L
//  config  | in        | i_cfg_valid / o_cfg_ready       | i_cfg_index, i_cfg_data
//
// Each word is worked on step by step, since every product goes through the one 33x25
// multiplier: 5 steps for the targets, 9 per wheel and one to load the result; the next
// word is accepted only after its result has been loaded.
// The output register holds a result while the next word is accepted and worked on; a full
// output register that is not taken holds the last step, with the input not ready.
// Reset is synchronous and restores the register defaults, clears both integrators
// and marks the next word as the first tick.
module diff_drive_wheel_pi_speed_control import ddw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [95:0]           s_axis_tdata,   // sim_time[47:0], speed_right, speed_left
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // torque_right[18:0], torque_left, zero pad
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LIN_W   = 20;
    localparam int ANG_W   = 22;
    localparam int TURN_W  = 22;
    localparam int SUM_W   = 23;
    localparam int TGT_W   = 31;
    localparam int ERR_W   = MUL_A_W;
    localparam int PTERM_W = 33;
    localparam int ITERM_W = 42;
    localparam int T_W     = 45;

    t_state r_state, n_state;
    t_mul_req w_req;

    logic signed [LIN_W-1:0]   r_lin;
    logic signed [ANG_W-1:0]   r_ang;
    logic [15:0]               r_htw;
    logic [23:0]               r_iwr;
    logic [15:0]               r_kp;
    logic [16:0]               r_ki;
    logic [15:0]               r_fc;
    logic [17:0]               r_tl;

    logic [TIME_W-1:0]         r_prev_time;
    logic                      r_first;
    logic signed [INTEG_W-1:0] r_integ_r, r_integ_l;

    logic [TIME_W-1:0]         r_dt;
    logic signed [SPEED_W-1:0] r_spd_r, r_spd_l;
    logic signed [SUM_W-1:0]   r_sum_r, r_sum_l;
    logic signed [TGT_W-1:0]   r_tgt_r, r_tgt_l;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PTERM_W-1:0] r_pterm;
    logic                      r_side;
    logic signed [TORQUE_W-1:0] r_tq_r, r_tq_l;
    logic                      r_out_valid;
    logic [TORQUE_W-1:0]       r_out_tq_r, r_out_tq_l;

    logic                      w_in_acc, w_cfg_acc, w_out_load;
    logic [TIME_W-1:0]         w_now, w_dt;
    logic signed [PROD_W-1:0]  w_prod, w_prod_fl;
    logic signed [TURN_W-1:0]  w_turn;
    logic signed [SPEED_W-1:0] w_spd_cur;
    logic signed [TGT_W-1:0]   w_tgt_cur;
    logic signed [INTEG_W-1:0] w_integ_cur, w_integ_new;
    logic signed [INTEG_W:0]   w_isum;
    logic                      w_stop;
    logic signed [ACC_W-1:0]   w_acc_fl;
    logic signed [T_W-1:0]     w_fric, w_t, w_lim;
    logic signed [TORQUE_W-1:0] w_tq;

    function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [ACC_W-1:0] x);
        if ((&x[ACC_W-1:INTEG_W-1]) || ~(|x[ACC_W-1:INTEG_W-1])) begin
            return x[INTEG_W-1:0];
        end else if (x[ACC_W-1]) begin
            return {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            return {1'b0, {(INTEG_W-1){1'b1}}};
        end
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign w_out_load    = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    assign w_now = s_axis_tdata[TIME_W-1:0];
    assign w_dt  = (r_first || (r_prev_time > w_now)) ? TIME_W'(NOMINAL_STEP)
                                                       : w_now - r_prev_time;

    ddw_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    assign w_prod_fl   = w_prod >>> FRAC_BITS;
    assign w_turn      = TURN_W'(w_prod_fl);
    assign w_spd_cur   = r_side ? r_spd_l : r_spd_r;
    assign w_tgt_cur   = r_side ? r_tgt_l : r_tgt_r;
    assign w_integ_cur = r_side ? r_integ_l : r_integ_r;
    assign w_acc_fl    = r_acc >>> FRAC_BITS;

    assign w_stop = (w_spd_cur < SPEED_W'(STOP_THRESH)) && (w_spd_cur > -SPEED_W'(STOP_THRESH))
                 && (r_err < ERR_W'(STOP_THRESH)) && (r_err > -ERR_W'(STOP_THRESH));
    assign w_isum = (INTEG_W+1)'(w_integ_cur) + (INTEG_W+1)'(sat_integ(w_acc_fl));
    assign w_integ_new = w_stop ? '0 : sat_integ(ACC_W'(w_isum));

    assign w_fric = (w_tgt_cur > 0) ? T_W'($signed({1'b0, r_fc}))
                  : (w_tgt_cur < 0) ? -T_W'($signed({1'b0, r_fc})) : '0;
    assign w_lim  = T_W'($signed({1'b0, r_tl}));
    assign w_t    = -T_W'(r_pterm) - T_W'(ITERM_W'(w_acc_fl)) + w_fric;
    assign w_tq   = (w_t > w_lim) ? TORQUE_W'(w_lim)
                  : (w_t < -w_lim) ? TORQUE_W'(-w_lim) : TORQUE_W'(w_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_req   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) n_state = ST_TURN;
            end
            ST_TURN: begin
                w_req = '{en: 1'b1, a: MUL_A_W'(r_ang), b: MUL_B_W'(r_htw)};
                n_state = ST_SUMS;
            end
            ST_SUMS: begin
                n_state = ST_TGT_R;
            end
            ST_TGT_R: begin
                w_req = '{en: 1'b1, a: MUL_A_W'(r_sum_r), b: MUL_B_W'(r_iwr)};
                n_state = ST_TGT_L;
            end
            ST_TGT_L: begin
                w_req = '{en: 1'b1, a: MUL_A_W'(r_sum_l), b: MUL_B_W'(r_iwr)};
                n_state = ST_TGT_W;
            end
            ST_TGT_W: begin
                n_state = ST_ERR;
            end
            ST_ERR: begin
                n_state = ST_DLO;
            end
            ST_DLO: begin
                w_req = '{en: 1'b1, a: r_err, b: MUL_B_W'(r_dt[HALF_W-1:0])};
                n_state = ST_DHI;
            end
            ST_DHI: begin
                w_req = '{en: 1'b1, a: r_err, b: MUL_B_W'(r_dt[TIME_W-1:HALF_W])};
                n_state = ST_DACC;
            end
            ST_DACC: begin
                n_state = ST_INTEG;
            end
            ST_INTEG: begin
                w_req = '{en: 1'b1, a: r_err, b: MUL_B_W'(r_kp)};
                n_state = ST_ILO;
            end
            ST_ILO: begin
                w_req = '{en: 1'b1, a: MUL_A_W'(r_ki), b: MUL_B_W'(w_integ_cur[HALF_W-1:0])};
                n_state = ST_IHI;
            end
            ST_IHI: begin
                w_req = '{en: 1'b1, a: MUL_A_W'(r_ki),
                          b: MUL_B_W'($signed(w_integ_cur[INTEG_W-1:HALF_W]))};
                n_state = ST_IACC;
            end
            ST_IACC: begin
                n_state = ST_TORQ;
            end
            ST_TORQ: begin
                n_state = r_side ? ST_DONE : ST_ERR;
            end
            ST_DONE: begin
                if (w_out_load) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin <= '0;
            r_ang <= '0;
            r_htw <= 16'd7537;
            r_iwr <= 24'd1861818;
            r_kp  <= 16'd6560;
            r_ki  <= 17'd13121;
            r_fc  <= 16'd13107;
            r_tl  <= 18'd98304;
        end else if (w_cfg_acc) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LIN_VEL:    r_lin <= i_cfg_data[LIN_W-1:0];
                CFG_ANG_VEL:    r_ang <= i_cfg_data[ANG_W-1:0];
                CFG_HALF_TRACK: r_htw <= i_cfg_data[15:0];
                CFG_INV_RADIUS: r_iwr <= i_cfg_data[23:0];
                CFG_KP:         r_kp  <= i_cfg_data[15:0];
                CFG_KI:         r_ki  <= i_cfg_data[16:0];
                CFG_FRICTION:   r_fc  <= i_cfg_data[15:0];
                CFG_TQ_LIMIT:   r_tl  <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_first     <= 1'b1;
            r_integ_r   <= '0;
            r_integ_l   <= '0;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_prev_time <= w_now;
                r_first     <= 1'b0;
                r_side      <= 1'b0;
            end
            if (r_state == ST_INTEG) begin
                if (r_side) r_integ_l <= w_integ_new;
                else        r_integ_r <= w_integ_new;
            end
            if (r_state == ST_TORQ && !r_side) begin
                r_side <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    r_dt    <= w_dt;
                    r_spd_r <= s_axis_tdata[TIME_W+SPEED_W-1:TIME_W];
                    r_spd_l <= s_axis_tdata[TIME_W+2*SPEED_W-1:TIME_W+SPEED_W];
                end
            end
            ST_SUMS: begin
                r_sum_r <= SUM_W'(r_lin) + SUM_W'(w_turn);
                r_sum_l <= SUM_W'(r_lin) - SUM_W'(w_turn);
            end
            ST_TGT_L: r_tgt_r <= TGT_W'(w_prod_fl);
            ST_TGT_W: r_tgt_l <= TGT_W'(w_prod_fl);
            ST_ERR:   r_err   <= ERR_W'(w_spd_cur) - ERR_W'(w_tgt_cur);
            ST_DHI:   r_acc   <= ACC_W'(w_prod);
            ST_DACC:  r_acc   <= r_acc + (ACC_W'(w_prod) <<< HALF_W);
            ST_ILO:   r_pterm <= PTERM_W'(w_prod_fl);
            ST_IHI:   r_acc   <= ACC_W'(w_prod);
            ST_IACC:  r_acc   <= r_acc + (ACC_W'(w_prod) <<< HALF_W);
            ST_TORQ: begin
                if (!r_side) r_tq_r <= w_tq;
                else         r_tq_l <= w_tq;
            end
            ST_DONE: begin
                if (w_out_load) begin
                    r_out_tq_r <= r_tq_r;
                    r_out_tq_l <= r_tq_l;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_tq_l, r_out_tq_r};

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_TURN))
        else $error("accepted word did not start the sequence");

    a_left_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TORQ && r_side) |=> (r_state == ST_DONE))
        else $error("second wheel did not finish the word");

    a_first_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_first) |-> $past(w_in_acc))
        else $error("first tick flag cleared without an accepted word");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside the done step");

endmodule
